// ----- rtl/srp_pkg.sv -----
// Package for the shelf rectangle placer: widths, codes and reset values.
`default_nettype none
package srp_pkg;

   localparam int COORD_BITS = 16;
   localparam int PAD_BITS   = 8;
   localparam int SUM_BITS   = COORD_BITS + 2;
   localparam int CSR_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [PAD_BITS-1:0]   pad_type;
   typedef logic [SUM_BITS-1:0]   sum_type;

   typedef enum logic [1:0] {
      STATUS_PLACED    = 2'd0,
      STATUS_ZERO_SIZE = 2'd1,
      STATUS_TOO_LARGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PAGE_WIDTH  = 2'd0,
      CSR_PAGE_HEIGHT = 2'd1,
      CSR_PAD         = 2'd2
   } csr_index_type;

   localparam coord_type PAGE_WIDTH_RESET  = coord_type'(2048);
   localparam coord_type PAGE_HEIGHT_RESET = coord_type'(2048);
   localparam pad_type   PAD_RESET         = '0;
   localparam coord_type PAGE_COUNT_MAX    = '1;

endpackage
`default_nettype wire

// ----- rtl/srp_ifs.sv -----
// Request and response channel interfaces of the shelf rectangle placer.
`default_nettype none
interface srp_req_if;
   import srp_pkg::*;

   logic      valid;
   logic      ready;
   coord_type rect_width;
   coord_type rect_height;

   modport source (output valid, output rect_width, output rect_height, input ready);
   modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

interface srp_rsp_if;
   import srp_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   coord_type  place_x;
   coord_type  place_y;
   coord_type  page_index;
   coord_type  used_w;
   coord_type  used_h;

   modport source (output valid, output status, output place_x, output place_y,
                   output page_index, output used_w, output used_h, input ready);
   modport sink   (input valid, input status, input place_x, input place_y,
                   input page_index, input used_w, input used_h, output ready);
endinterface
`default_nettype wire

// ----- rtl/shelf_rect_placer.sv -----
// Shelf next-fit rectangle placer: places one rectangle per request into padded pages.
//
// Usage: a request on req_chan carries one rectangle (rect_width x rect_height).
// Every request yields exactly one response on rsp_chan, in order: a status
// (placed, zero size, too large), the top-left position, the page index and the
// used extents of the current page. Requests that are not placed leave the
// packing state untouched.
// An accepted request sits in the request register and is placed when it moves into
// the response register, which drives rsp_chan.valid and the response fields.
// Throughput is one request per cycle while the receiver takes responses; the only loop is the cursor and shelf
// state, which is read and updated in that single placement step.
// When the receiver stalls, the response register holds and the request
// register fills; req_chan.ready then falls until the response is taken.
// The user must write page size and padding via the csr_ port only while no request
// is in flight; the block does not enforce it. Reset (synchronous, active high)
// restores the default page size of 2048 x 2048, zero padding and an empty page
// set; the first placement opens page 0. The page index saturates at its maximum.
`default_nettype none
module shelf_rect_placer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   srp_req_if.sink                            req_chan,
   srp_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [srp_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [srp_pkg::CSR_BITS-1:0]     csr_wdata
);
   import srp_pkg::*;

   // configuration
   coord_type page_width_ff;
   coord_type page_height_ff;
   pad_type   pad_ff;

   // packing state
   coord_type pen_x_ff, pen_x_in;
   coord_type pen_y_ff, pen_y_in;
   coord_type shelf_h_ff, shelf_h_in;
   coord_type extent_w_ff, extent_w_in;
   coord_type extent_h_ff, extent_h_in;
   coord_type page_count_ff, page_count_in;
   logic      page_open_ff;

   // request register
   logic      in_valid_ff;
   coord_type in_w_ff;
   coord_type in_h_ff;

   // response register
   logic       out_valid_ff;
   status_type out_status_ff, out_status_in;
   coord_type  out_x_ff, out_x_in;
   coord_type  out_y_ff, out_y_in;
   coord_type  out_page_ff;
   coord_type  out_used_w_ff;
   coord_type  out_used_h_ff;

   logic advance;
   logic place;

   // placement datapath
   sum_type w_s, h_s, p_s, pw_s, ph_s;
   sum_type cur_x, cur_y, shelf_s, cx, cy, end_x, end_y;
   logic    wrap, new_page;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_width_ff  <= PAGE_WIDTH_RESET;
         page_height_ff <= PAGE_HEIGHT_RESET;
         pad_ff         <= PAD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_WIDTH:  page_width_ff  <= coord_type'(csr_wdata);
            CSR_PAGE_HEIGHT: page_height_ff <= coord_type'(csr_wdata);
            CSR_PAD:         pad_ff         <= csr_wdata[PAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_w_ff <= req_chan.rect_width;
         in_h_ff <= req_chan.rect_height;
      end
   end

   always_comb begin
      w_s     = sum_type'(in_w_ff);
      h_s     = sum_type'(in_h_ff);
      p_s     = sum_type'(pad_ff);
      pw_s    = sum_type'(page_width_ff);
      ph_s    = sum_type'(page_height_ff);
      // no page yet: behave as a freshly opened page
      cur_x   = page_open_ff ? sum_type'(pen_x_ff) : p_s;
      cur_y   = page_open_ff ? sum_type'(pen_y_ff) : p_s;
      shelf_s = page_open_ff ? sum_type'(shelf_h_ff) : '0;

      out_status_in = STATUS_PLACED;
      if (in_w_ff == '0 || in_h_ff == '0) begin
         out_status_in = STATUS_ZERO_SIZE;
      end else if (w_s + (p_s << 1) > pw_s || h_s + (p_s << 1) > ph_s) begin
         out_status_in = STATUS_TOO_LARGE;
      end
      place = (out_status_in == STATUS_PLACED);

      wrap     = cur_x + w_s + p_s > pw_s;
      cx       = wrap ? p_s : cur_x;
      cy       = wrap ? cur_y + shelf_s + p_s : cur_y;
      shelf_s  = wrap ? '0 : shelf_s;
      new_page = cy + h_s + p_s > ph_s;

      page_count_in = page_open_ff ? page_count_ff : '0;
      extent_w_in   = page_open_ff ? extent_w_ff : '0;
      extent_h_in   = page_open_ff ? extent_h_ff : '0;
      if (new_page) begin
         if (page_open_ff && page_count_ff != PAGE_COUNT_MAX) begin
            page_count_in = page_count_ff + 1'b1;
         end
         cx          = p_s;
         cy          = p_s;
         shelf_s     = '0;
         extent_w_in = '0;
         extent_h_in = '0;
      end

      end_x = cx + w_s + p_s;
      end_y = cy + h_s + p_s;
      pen_x_in   = end_x[COORD_BITS-1:0];
      pen_y_in   = cy[COORD_BITS-1:0];
      shelf_h_in = (h_s > shelf_s) ? in_h_ff : shelf_s[COORD_BITS-1:0];
      if (end_x > sum_type'(extent_w_in)) extent_w_in = end_x[COORD_BITS-1:0];
      if (end_y > sum_type'(extent_h_in)) extent_h_in = end_y[COORD_BITS-1:0];

      out_x_in = place ? cx[COORD_BITS-1:0] : '0;
      out_y_in = place ? cy[COORD_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         shelf_h_ff    <= '0;
         extent_w_ff   <= '0;
         extent_h_ff   <= '0;
         page_count_ff <= '0;
         page_open_ff  <= 1'b0;
      end else if (advance && place) begin
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         shelf_h_ff    <= shelf_h_in;
         extent_w_ff   <= extent_w_in;
         extent_h_ff   <= extent_h_in;
         page_count_ff <= page_count_in;
         page_open_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // unplaced requests report the current page (all zero before the first page)
   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff <= out_status_in;
         out_x_ff      <= out_x_in;
         out_y_ff      <= out_y_in;
         out_page_ff   <= place ? page_count_in : page_count_ff;
         out_used_w_ff <= place ? extent_w_in : extent_w_ff;
         out_used_h_ff <= place ? extent_h_in : extent_h_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.status     = out_status_ff;
   assign rsp_chan.place_x    = out_x_ff;
   assign rsp_chan.place_y    = out_y_ff;
   assign rsp_chan.page_index = out_page_ff;
   assign rsp_chan.used_w     = out_used_w_ff;
   assign rsp_chan.used_h     = out_used_h_ff;

   // once a page is open it stays open
   a_page_stays_open: assert property (@(posedge clock) disable iff (reset)
      page_open_ff |=> page_open_ff)
      else $error("page closed after opening");

   // the page index moves by at most one per cycle
   a_page_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         (page_count_ff == $past(page_count_ff) ||
          page_count_ff == $past(page_count_ff) + 1'b1))
      else $error("page index jumped");

   // a placed rectangle lies inside the reported used width and height
   a_placed_in_extent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == STATUS_PLACED |->
         out_used_w_ff > out_x_ff && out_used_h_ff > out_y_ff)
      else $error("placed rectangle outside used extent");

   // a held request is not dropped while the response side stalls
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_w_ff) && $stable(in_h_ff))
      else $error("stalled request lost");

   // no placement state change without a response being loaded
   a_state_with_response: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pen_x_ff) && $stable(pen_y_ff) && $stable(page_count_ff))
      else $error("packing state changed without a request");

endmodule
`default_nettype wire
